### rtl/core/ueb_pkg.sv
// Shared types, constants and helpers for the UTC epoch breakdown pipeline.
// No dependencies; imported by utc_epoch_breakdown_and_bucket.
`default_nettype none

package ueb_pkg;

    // Field widths fixed by the interface
    localparam int EPOCH_W = 39;
    localparam int YEAR_W  = 14;

    // Number of register stages, output register included
    localparam int NSTG = 14;

    // 0001-01-01 00:00:00 and 9999-12-31 23:59:59 as epoch seconds
    localparam logic signed [EPOCH_W-1:0] EPOCH_MIN = -39'sd62135596800;
    localparam logic signed [EPOCH_W-1:0] EPOCH_MAX = 39'sd253402300799;

    // Days from 0001-01-01 to the era base 0000-03-01, as an offset on day numbers
    localparam logic [21:0] ERA_SHIFT = 22'd306;
    localparam logic [17:0] DAYS_ERA  = 18'd146097;
    localparam logic [17:0] LAST_DOE  = 18'd146096;

    // Bucket unit codes
    localparam logic [1:0] BKT_DAY   = 2'd0;
    localparam logic [1:0] BKT_WEEK  = 2'd1;
    localparam logic [1:0] BKT_MONTH = 2'd2;
    localparam logic [1:0] BKT_YEAR  = 2'd3;

    // Exact reciprocals: floor(x/d) == (x*ceil(2^k/d)) >> k for x < 2^n, k = n + clog2(d)
    localparam longint unsigned RCP_675    = ((64'd1 << 42) + 64'd674) / 64'd675;
    localparam longint unsigned RCP_7      = ((64'd1 << 25) + 64'd6) / 64'd7;
    localparam longint unsigned RCP_146097 = ((64'd1 << 40) + 64'd146096) / 64'd146097;
    localparam longint unsigned RCP_3600   = ((64'd1 << 29) + 64'd3599) / 64'd3600;
    localparam longint unsigned RCP_60     = ((64'd1 << 18) + 64'd59) / 64'd60;
    localparam longint unsigned RCP_1460   = ((64'd1 << 29) + 64'd1459) / 64'd1460;
    localparam longint unsigned RCP_36524  = ((64'd1 << 34) + 64'd36523) / 64'd36524;
    localparam longint unsigned RCP_365    = ((64'd1 << 27) + 64'd364) / 64'd365;
    localparam longint unsigned RCP_100    = ((64'd1 << 16) + 64'd99) / 64'd100;
    localparam longint unsigned RCP_153    = ((64'd1 << 19) + 64'd152) / 64'd153;

    // One pipeline word; each stage fills in the fields it owns
    typedef struct packed {
        logic                      err;
        logic [31:0]               x;
        logic [6:0]                lo7;
        logic [21:0]               dnum;
        logic [21:0]               znum;
        logic [16:0]               rem;
        logic [19:0]               q7;
        logic [2:0]                wd;
        logic [4:0]                era;
        logic [4:0]                hour;
        logic [17:0]               doe;
        logic [11:0]               r3600;
        logic [6:0]                q1460;
        logic [2:0]                q36524;
        logic                      last_doe;
        logic [5:0]                minute;
        logic [17:0]               tval;
        logic [5:0]                second;
        logic [8:0]                yoe;
        logic [1:0]                q100;
        logic [8:0]                doy;
        logic                      leap;
        logic [3:0]                mp;
        logic [YEAR_W-1:0]         year;
        logic [3:0]                month;
        logic [4:0]                mday;
        logic [21:0]               dstart;
        logic [EPOCH_W-1:0]        bprod;
        logic signed [EPOCH_W-1:0] bstart;
    } pipe_t;

    // Day of the March-based year on which month index mp begins
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] res;
        case (mp)
            4'd0:    res = 9'd0;
            4'd1:    res = 9'd31;
            4'd2:    res = 9'd61;
            4'd3:    res = 9'd92;
            4'd4:    res = 9'd122;
            4'd5:    res = 9'd153;
            4'd6:    res = 9'd184;
            4'd7:    res = 9'd214;
            4'd8:    res = 9'd245;
            4'd9:    res = 9'd275;
            4'd10:   res = 9'd306;
            4'd11:   res = 9'd337;
            default: res = 9'd0;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

### rtl/core/utc_epoch_breakdown_and_bucket.sv
// Usage
// -----
// Input channel: in_valid / in_stall with epoch_seconds (signed seconds since
// 1970-01-01 UTC). Output channel: out_valid / out_stall with the civil
// breakdown, weekday (Monday = 0), bucket_start and range_error.
// Config channel: cfg_valid / cfg_ready with cfg_data = bucket unit
// (day, Monday week, month, year). cfg_ready is always high; write it only
// while the pipeline is empty.
// Throughput: one word per cycle while out_stall is low. The work runs through
// a 14-stage pipeline (range check, divide by 86400, era split, year/day split,
// month split, bucket start, output register); each word passes through the
// stages in order and shows on the outputs from the output register.
// Out-of-range input (outside years 1..9999) gives range_error = 1 and all
// other fields zero.
// out_stall freezes only the stages that hold a word and cannot move on;
// bubbles close up, so input is taken while a result waits at the output as long as some stage is empty.
// Reset empties the pipeline and sets the bucket unit to day.
// Depends on ueb_pkg.
`default_nettype none

module utc_epoch_breakdown_and_bucket
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [1:0]                             cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [ueb_pkg::EPOCH_W-1:0]     epoch_seconds,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [ueb_pkg::EPOCH_W-1:0]     bucket_start,
    output logic [ueb_pkg::YEAR_W-1:0]             year_out,
    output logic [3:0]                             month_out,
    output logic [4:0]                             day_out,
    output logic [4:0]                             hour_out,
    output logic [5:0]                             minute_out,
    output logic [5:0]                             second_out,
    output logic [2:0]                             weekday_out,
    output logic                                   range_error
);

    import ueb_pkg::*;

    localparam int LAST = NSTG - 1;

    pipe_t           stage_reg  [NSTG];
    pipe_t           stage_next [NSTG];
    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] adv;
    logic [1:0]      bucket_unit_reg;

    // ---------------- handshake ----------------
    assign adv[LAST] = !valid_reg[LAST] || !out_stall;

    genvar g;
    generate
        for (g = 0; g < LAST; g++)
        begin : g_adv
            assign adv[g] = !valid_reg[g] || adv[g+1];
        end
    endgenerate

    assign in_stall  = !adv[0];
    assign out_valid = valid_reg[LAST];
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            bucket_unit_reg <= BKT_DAY;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                bucket_unit_reg <= cfg_data;
            end
            if (adv[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < NSTG; k++)
            begin
                if (adv[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NSTG; k++)
        begin
            if (adv[k])
            begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    // ---------------- datapath ----------------
    logic [EPOCH_W-1:0] u_off;
    logic [64:0]        p675;
    logic [31:0]        p675m;
    logic [9:0]         r675;
    logic [44:0]        p7;
    logic [44:0]        p_era;
    logic [34:0]        p_hr;
    logic [22:0]        p146097;
    logic [16:0]        p3600;
    logic [16:0]        rw3600;
    logic [36:0]        p1460;
    logic [36:0]        p36524;
    logic [24:0]        p_min;
    logic [18:0]        tw;
    logic [11:0]        p60;
    logic [11:0]        sw;
    logic [36:0]        p365;
    logic [18:0]        p100;
    logic [17:0]        yoe365;
    logic [18:0]        doy_sub;
    logic [18:0]        doyw;
    logic [10:0]        v153;
    logic [22:0]        p153;
    logic [8:0]         ms;
    logic               jan_feb;
    logic [22:0]        dbase;
    logic [22:0]        dsel;
    logic [44:0]        pday;

    always_comb
    begin
        // stage 0: range check, offset to 0001-01-01
        stage_next[0]     = '0;
        u_off             = epoch_seconds - EPOCH_MIN;
        stage_next[0].err = (epoch_seconds < EPOCH_MIN) || (epoch_seconds > EPOCH_MAX);
        stage_next[0].x   = u_off[EPOCH_W-1:7];
        stage_next[0].lo7 = u_off[6:0];

        // stage 1: day number = (u >> 7) / 675
        stage_next[1]      = stage_reg[0];
        p675               = 65'(stage_reg[0].x) * 65'(RCP_675);
        stage_next[1].dnum = p675[63:42];

        // stage 2: seconds of day, era-based day number, weekday quotient
        stage_next[2]      = stage_reg[1];
        p675m              = 32'(stage_reg[1].dnum) * 32'd675;
        r675               = stage_reg[1].x[9:0] - p675m[9:0];
        stage_next[2].rem  = {r675, stage_reg[1].lo7};
        stage_next[2].znum = stage_reg[1].dnum + ERA_SHIFT;
        p7                 = 45'(stage_reg[1].dnum) * 45'(RCP_7);
        stage_next[2].q7   = p7[44:25];

        // stage 3: weekday, era, hour
        stage_next[3]      = stage_reg[2];
        stage_next[3].wd   = stage_reg[2].dnum[2:0] - 3'(stage_reg[2].q7 * 20'd7);
        p_era              = 45'(stage_reg[2].znum) * 45'(RCP_146097);
        stage_next[3].era  = p_era[44:40];
        p_hr               = 35'(stage_reg[2].rem) * 35'(RCP_3600);
        stage_next[3].hour = p_hr[33:29];

        // stage 4: day of era, seconds within hour
        stage_next[4]       = stage_reg[3];
        p146097             = 23'(stage_reg[3].era) * 23'(DAYS_ERA);
        stage_next[4].doe   = stage_reg[3].znum[17:0] - p146097[17:0];
        p3600               = 17'(stage_reg[3].hour) * 17'd3600;
        rw3600              = stage_reg[3].rem - p3600;
        stage_next[4].r3600 = rw3600[11:0];

        // stage 5: leap corrections of day of era, minute
        stage_next[5]          = stage_reg[4];
        p1460                  = 37'(stage_reg[4].doe) * 37'(RCP_1460);
        stage_next[5].q1460    = p1460[35:29];
        p36524                 = 37'(stage_reg[4].doe) * 37'(RCP_36524);
        stage_next[5].q36524   = p36524[36:34];
        stage_next[5].last_doe = (stage_reg[4].doe == LAST_DOE);
        p_min                  = 25'(stage_reg[4].r3600) * 25'(RCP_60);
        stage_next[5].minute   = p_min[23:18];

        // stage 6: corrected day count, second
        stage_next[6]        = stage_reg[5];
        tw                   = 19'(stage_reg[5].doe) - 19'(stage_reg[5].q1460)
                             + 19'(stage_reg[5].q36524) - 19'(stage_reg[5].last_doe);
        stage_next[6].tval   = tw[17:0];
        p60                  = 12'(stage_reg[5].minute) * 12'd60;
        sw                   = stage_reg[5].r3600 - p60;
        stage_next[6].second = sw[5:0];

        // stage 7: year of era
        stage_next[7]     = stage_reg[6];
        p365              = 37'(stage_reg[6].tval) * 37'(RCP_365);
        stage_next[7].yoe = p365[35:27];

        // stage 8: centuries in year of era
        stage_next[8]      = stage_reg[7];
        p100               = 19'(stage_reg[7].yoe) * 19'(RCP_100);
        stage_next[8].q100 = p100[17:16];

        // stage 9: day of March-based year, leap flag of the civil year
        stage_next[9]      = stage_reg[8];
        yoe365             = 18'(stage_reg[8].yoe) * 18'd365;
        doy_sub            = 19'(yoe365) + 19'(stage_reg[8].yoe[8:2])
                           - 19'(stage_reg[8].q100);
        doyw               = 19'(stage_reg[8].doe) - doy_sub;
        stage_next[9].doy  = doyw[8:0];
        stage_next[9].leap = (stage_reg[8].yoe[1:0] == 2'd0)
                           && (stage_reg[8].yoe != 9'd100)
                           && (stage_reg[8].yoe != 9'd200)
                           && (stage_reg[8].yoe != 9'd300);

        // stage 10: month index from March
        stage_next[10]    = stage_reg[9];
        v153              = 11'(stage_reg[9].doy) * 11'd5 + 11'd2;
        p153              = 23'(v153) * 23'(RCP_153);
        stage_next[10].mp = p153[22:19];

        // stage 11: civil date and first day of the bucket
        stage_next[11]       = stage_reg[10];
        ms                   = month_start(stage_reg[10].mp);
        jan_feb              = (stage_reg[10].mp >= 4'd10);
        stage_next[11].mday  = 5'(stage_reg[10].doy - ms + 9'd1);
        stage_next[11].month = jan_feb ? (stage_reg[10].mp - 4'd9) : (stage_reg[10].mp + 4'd3);
        stage_next[11].year  = YEAR_W'(stage_reg[10].yoe)
                             + YEAR_W'(stage_reg[10].era) * YEAR_W'(400)
                             + YEAR_W'(jan_feb);
        // day number of March 1 of the current March-based year
        dbase                = 23'(stage_reg[10].dnum) - 23'(stage_reg[10].doy);
        case (bucket_unit_reg)
            BKT_DAY:   dsel = 23'(stage_reg[10].dnum);
            BKT_WEEK:  dsel = 23'(stage_reg[10].dnum) - 23'(stage_reg[10].wd);
            BKT_MONTH: dsel = dbase + 23'(ms);
            default:
            begin
                // Jan 1 lies 306 days into this March year, or 59/60 days before it
                if (jan_feb)
                    dsel = dbase + 23'd306;
                else
                    dsel = dbase - 23'd59 - 23'(stage_reg[10].leap);
            end
        endcase
        stage_next[11].dstart = dsel[21:0];

        // stage 12: bucket start in seconds from 0001-01-01
        stage_next[12]       = stage_reg[11];
        pday                 = 45'(stage_reg[11].dstart) * 45'd86400;
        stage_next[12].bprod = pday[EPOCH_W-1:0];

        // stage 13: output word, zeroed on range error
        stage_next[13]        = stage_reg[12];
        stage_next[13].bstart = $signed(stage_reg[12].bprod) + EPOCH_MIN;
        if (stage_reg[12].err)
        begin
            stage_next[13].bstart = '0;
            stage_next[13].year   = '0;
            stage_next[13].month  = '0;
            stage_next[13].mday   = '0;
            stage_next[13].hour   = '0;
            stage_next[13].minute = '0;
            stage_next[13].second = '0;
            stage_next[13].wd     = '0;
        end
    end

    assign bucket_start = stage_reg[LAST].bstart;
    assign year_out     = stage_reg[LAST].year;
    assign month_out    = stage_reg[LAST].month;
    assign day_out      = stage_reg[LAST].mday;
    assign hour_out     = stage_reg[LAST].hour;
    assign minute_out   = stage_reg[LAST].minute;
    assign second_out   = stage_reg[LAST].second;
    assign weekday_out  = stage_reg[LAST].wd;
    assign range_error  = stage_reg[LAST].err;

`ifndef SYNTH
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && range_error |-> bucket_start == '0 && year_out == '0
            && month_out == '0 && day_out == '0 && weekday_out == '0)
        else $error("range error word carries nonzero fields");

    a_date_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !range_error |-> month_out >= 4'd1 && month_out <= 4'd12
            && day_out >= 5'd1 && year_out >= 14'd1 && year_out <= 14'd9999)
        else $error("civil date out of bounds");

    a_time_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !range_error |-> hour_out <= 5'd23 && minute_out <= 6'd59
            && second_out <= 6'd59 && weekday_out <= 3'd6)
        else $error("time of day or weekday out of bounds");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while output register empty");
`endif

endmodule

`default_nettype wire
